### design/steering_pd_from_three_sensors_assert.svh
// assertion macros for the steering pd block
// no dependencies; included by the top level
`ifndef STEERING_PD_FROM_THREE_SENSORS_ASSERT_SVH
`define STEERING_PD_FROM_THREE_SENSORS_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SPD_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("spd assertion failed");

// condition must hold in the cycle after the trigger
`define SPD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("spd assertion failed");

`endif

### design/spd_pkg.sv
// shared types and constants of the steering pd block
// no dependencies; used by every other file but the assertion header
package spd_pkg;

   localparam int SAMPLE_W    = 13;
   localparam int ERR_W       = 15;
   localparam int DIFF_W      = ERR_W + 1;
   localparam int GAIN_W      = 8;
   localparam int DUTY_W      = 13;
   localparam int LOST_W      = 2;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 13;
   localparam int QUOT_W      = 20;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // lost test margin and forced error bias
   localparam logic [SAMPLE_W:0]      LOST_MARGIN = 14'd20;
   localparam logic signed [ERR_W-1:0] LOST_BIAS  = 15'sd50;

   // drive limit and servo center
   localparam logic [QUOT_W-1:0] DRIVE_LIMIT = 20'd800;
   localparam logic [DUTY_W-1:0] DUTY_CENTER = 13'd6000;

   // divide by 20 = shift by 2, then multiply by a rounded-up 1/5
   localparam int RECIP_SHIFT = 24;
   localparam logic [21:0] DIV5_RECIP = 22'(((2 ** RECIP_SHIFT) + 4) / 5);

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 8'd30;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 8'd20;

   typedef enum logic [LOST_W-1:0] {
      LOST_NONE  = 2'd0,
      LOST_RIGHT = 2'd1,
      LOST_LEFT  = 2'd2
   } lost_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SIDE_OFFSET     = 8'd0,
      REG_OFFSET_ON_RIGHT = 8'd1,
      REG_OUTER_LOW       = 8'd2,
      REG_OUTER_HIGH      = 8'd3,
      REG_CENTER_REF_R    = 8'd4,
      REG_CENTER_REF_L    = 8'd5,
      REG_GAIN_P          = 8'd6,
      REG_GAIN_D          = 8'd7
   } csr_reg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] side_offset;
      logic                offset_on_right;
      logic [SAMPLE_W-1:0] outer_low;
      logic [SAMPLE_W-1:0] outer_high;
      logic [SAMPLE_W-1:0] center_ref_right_lost;
      logic [SAMPLE_W-1:0] center_ref_left_lost;
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_d;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] steer_error;
      lost_type                line_lost;
   } front_item_type;

endpackage

### design/spd_if.sv
// channel interfaces of the steering pd block: request, response, csr
// depends on spd_pkg
interface spd_req_if import spd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] right_sample;
   logic [SAMPLE_W-1:0] left_sample;
   logic [SAMPLE_W-1:0] center_sample;

   modport source (output valid, right_sample, left_sample, center_sample, input ready);
   modport sink (input valid, right_sample, left_sample, center_sample, output ready);
endinterface

interface spd_rsp_if import spd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       servo_duty;
   logic signed [ERR_W-1:0] steer_error;
   logic [LOST_W-1:0]       line_lost;
   logic                    clamped;

   modport source (output valid, servo_duty, steer_error, line_lost, clamped, input ready);
   modport sink (input valid, servo_duty, steer_error, line_lost, clamped, output ready);
endinterface

interface spd_csr_if import spd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/steering_pd_from_three_sensors.sv
// top level of the steering pd block: csr registers, front, queue, back
// depends on spd_pkg, spd_if, spd_front, spd_queue, spd_back and the assertion header
`include "steering_pd_from_three_sensors_assert.svh"

// Steering PD controller on three line sensors. One sample beat (right, left,
// center) gives one response beat (servo duty, error, lost code, clamp flag).
// The block takes one beat per cycle when the response side keeps up. The front end
// classifies a beat in the cycle of acceptance and it is written into a short queue;
// then the back end spends four register stages on the gain products, the divide by
// 20, and the clamp, the first of them loading from the queue.
// The derivative term uses the error of the previous beat, carried in one
// register of the back end. The queue (QUEUE_DEPTH beats) lets the input keep
// flowing while the response side stalls, until it fills. Csr writes are
// always accepted and should only be made while no beat is in flight.
module steering_pd_from_three_sensors import spd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   spd_req_if.sink    req_ch,
   spd_rsp_if.source  rsp_ch,
   spd_csr_if.sink    csr_ch
);

   localparam logic [DUTY_W-1:0] DUTY_LOW  = DUTY_CENTER - DRIVE_LIMIT[DUTY_W-1:0];
   localparam logic [DUTY_W-1:0] DUTY_HIGH = DUTY_CENTER + DRIVE_LIMIT[DUTY_W-1:0];

   cfg_type        cfg_ff;
   logic           push_valid;
   logic           push_ready;
   front_item_type push_item;
   logic           pop_valid;
   logic           pop_ready;
   front_item_type pop_item;
   logic           duty_in_window;
   logic           duty_at_limit;

   assign csr_ch.ready = 1'b1;

   // csr register file, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.side_offset           <= '0;
         cfg_ff.offset_on_right       <= 1'b0;
         cfg_ff.outer_low             <= '0;
         cfg_ff.outer_high            <= '0;
         cfg_ff.center_ref_right_lost <= '0;
         cfg_ff.center_ref_left_lost  <= '0;
         cfg_ff.gain_p                <= GAIN_P_RESET;
         cfg_ff.gain_d                <= GAIN_D_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SIDE_OFFSET: begin
               cfg_ff.side_offset <= csr_ch.data;
            end
            REG_OFFSET_ON_RIGHT: begin
               cfg_ff.offset_on_right <= csr_ch.data[0];
            end
            REG_OUTER_LOW: begin
               cfg_ff.outer_low <= csr_ch.data;
            end
            REG_OUTER_HIGH: begin
               cfg_ff.outer_high <= csr_ch.data;
            end
            REG_CENTER_REF_R: begin
               cfg_ff.center_ref_right_lost <= csr_ch.data;
            end
            REG_CENTER_REF_L: begin
               cfg_ff.center_ref_left_lost <= csr_ch.data;
            end
            REG_GAIN_P: begin
               cfg_ff.gain_p <= csr_ch.data[GAIN_W-1:0];
            end
            REG_GAIN_D: begin
               cfg_ff.gain_d <= csr_ch.data[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   spd_front u_front (
      .req        (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   spd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   spd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_ch)
   );

   // duty window checks
   assign duty_in_window = (rsp_ch.servo_duty >= DUTY_LOW) && (rsp_ch.servo_duty <= DUTY_HIGH);
   assign duty_at_limit  = (rsp_ch.servo_duty == DUTY_LOW) || (rsp_ch.servo_duty == DUTY_HIGH);

   // duty stays inside the clamp window
   `SPD_ASSERT_SAME(a_duty_window, clock, reset, rsp_ch.valid, duty_in_window)
   // a clamped beat sits on one of the two limits
   `SPD_ASSERT_SAME(a_clamp_at_limit, clock, reset, rsp_ch.valid && rsp_ch.clamped, duty_at_limit)
   // a stalled response beat is still there next cycle
   `SPD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid)
   // front never pushes into a full queue when the input is taken
   `SPD_ASSERT_SAME(a_push_room, clock, reset, req_ch.valid && req_ch.ready, push_ready)

endmodule

### design/spd_front.sv
// front end: applies the side offset, runs the lost tests, forms the error
// depends on spd_pkg and spd_req_if
module spd_front import spd_pkg::*; (
   spd_req_if.sink         req,
   input  cfg_type         cfg,
   output logic            push_valid,
   input  logic            push_ready,
   output front_item_type  push_item
);

   logic [SAMPLE_W:0]       right_adj;
   logic [SAMPLE_W:0]       left_adj;
   logic signed [ERR_W-1:0] err_track;
   logic signed [ERR_W-1:0] err_right_lost;
   logic signed [ERR_W-1:0] err_left_lost;
   logic                    right_lost;
   logic                    left_lost;

   // offset goes to the side that read weaker at calibration
   always_comb begin
      right_adj = {1'b0, req.right_sample};
      left_adj  = {1'b0, req.left_sample};
      if (cfg.offset_on_right) begin
         right_adj = right_adj + {1'b0, cfg.side_offset};
      end else begin
         left_adj = left_adj + {1'b0, cfg.side_offset};
      end
      err_track = $signed({1'b0, left_adj}) - $signed({1'b0, right_adj});
   end

   // lost when center sits below its reference plus the margin
   assign right_lost = {1'b0, req.center_sample} < ({1'b0, cfg.center_ref_right_lost} + LOST_MARGIN);
   assign left_lost  = {1'b0, req.center_sample} < ({1'b0, cfg.center_ref_left_lost} + LOST_MARGIN);

   assign err_right_lost = $signed({2'b00, cfg.outer_low}) - $signed({2'b00, cfg.outer_high})
                           + LOST_BIAS;
   assign err_left_lost  = $signed({2'b00, cfg.outer_high}) - $signed({2'b00, cfg.outer_low})
                           - LOST_BIAS;

   // left lost is checked first and wins
   always_comb begin
      if (left_lost) begin
         push_item.steer_error = err_left_lost;
         push_item.line_lost   = LOST_LEFT;
      end else if (right_lost) begin
         push_item.steer_error = err_right_lost;
         push_item.line_lost   = LOST_RIGHT;
      end else begin
         push_item.steer_error = err_track;
         push_item.line_lost   = LOST_NONE;
      end
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

### design/spd_queue.sv
// short fifo between the front and back ends
// depends on spd_pkg
module spd_queue import spd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  front_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output front_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   front_item_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/spd_back.sv
// back end: pd products, divide by 20, clamp and servo duty in four stages
// depends on spd_pkg and spd_rsp_if
module spd_back import spd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  front_item_type pop_item,
   spd_rsp_if.source      rsp
);

   // stage valids and stall chain
   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic ready_a, ready_b, ready_c, ready_d;

   // previous error, taken as each beat enters stage a
   logic signed [ERR_W-1:0] prev_ff;

   // stage a: products
   logic signed [DIFF_W-1:0]  diff;
   logic signed [23:0]        prod_p_in, prod_p_ff;
   logic signed [24:0]        prod_d_in, prod_d_ff;
   front_item_type            item_a_ff;

   // stage b: magnitude over 4
   logic signed [25:0]        sum;
   logic [25:0]               mag;
   logic [21:0]               quarter_ff;
   logic                      neg_b_ff;
   front_item_type            item_b_ff;

   // stage c: times 1/5
   logic [43:0]               scaled;
   logic [QUOT_W-1:0]         quot_ff;
   logic                      neg_c_ff;
   front_item_type            item_c_ff;

   // stage d: clamp and duty
   logic [QUOT_W-1:0]         quot_lim;
   logic                      clamp_in;
   logic [DUTY_W-1:0]         duty_in, duty_ff;
   logic                      clamp_ff;
   front_item_type            item_d_ff;

   assign ready_d   = !vd_ff || rsp.ready;
   assign ready_c   = !vc_ff || ready_d;
   assign ready_b   = !vb_ff || ready_c;
   assign ready_a   = !va_ff || ready_b;
   assign pop_ready = ready_a;

   always_comb begin
      diff      = $signed({pop_item.steer_error[ERR_W-1], pop_item.steer_error})
                  - $signed({prev_ff[ERR_W-1], prev_ff});
      prod_p_in = $signed({1'b0, cfg.gain_p}) * pop_item.steer_error;
      prod_d_in = $signed({1'b0, cfg.gain_d}) * diff;
   end

   always_comb begin
      sum = $signed({{2{prod_p_ff[23]}}, prod_p_ff}) + $signed({prod_d_ff[24], prod_d_ff});
      mag = sum[25] ? 26'(-sum) : 26'(sum);
   end

   assign scaled = quarter_ff * DIV5_RECIP;

   // magnitude limit, then sign back on around the center
   always_comb begin
      clamp_in = quot_ff > DRIVE_LIMIT;
      quot_lim = clamp_in ? DRIVE_LIMIT : quot_ff;
      duty_in  = neg_c_ff ? DUTY_CENTER - quot_lim[DUTY_W-1:0]
                          : DUTY_CENTER + quot_lim[DUTY_W-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         vd_ff   <= 1'b0;
         prev_ff <= '0;
      end else begin
         if (ready_a) begin
            va_ff <= pop_valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
         if (ready_d) begin
            vd_ff <= vc_ff;
         end
         if (pop_valid && ready_a) begin
            prev_ff <= pop_item.steer_error;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ready_a) begin
         prod_p_ff <= prod_p_in;
         prod_d_ff <= prod_d_in;
         item_a_ff <= pop_item;
      end
      if (ready_b) begin
         quarter_ff <= mag[23:2];
         neg_b_ff   <= sum[25];
         item_b_ff  <= item_a_ff;
      end
      if (ready_c) begin
         quot_ff   <= scaled[RECIP_SHIFT +: QUOT_W];
         neg_c_ff  <= neg_b_ff;
         item_c_ff <= item_b_ff;
      end
      if (ready_d) begin
         duty_ff   <= duty_in;
         clamp_ff  <= clamp_in;
         item_d_ff <= item_c_ff;
      end
   end

   assign rsp.valid       = vd_ff;
   assign rsp.servo_duty  = duty_ff;
   assign rsp.steer_error = item_d_ff.steer_error;
   assign rsp.line_lost   = item_d_ff.line_lost;
   assign rsp.clamped     = clamp_ff;

endmodule

### tb/steering_pd_from_three_sensors_tb.sv
// self-checking testbench for the steering pd block: directed table, then random phases
// depends on spd_pkg, spd_if and the steering_pd_from_three_sensors top level
`timescale 1ns / 100ps

module steering_pd_from_three_sensors_tb;
   import spd_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_GAP        = 18;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BEATS    = 100;
   localparam int SAMPLE_MAX     = 8191;
   localparam int GAIN_MAX       = 255;

   // steering law constants
   localparam int LOST_WINDOW = 20;
   localparam int FORCED_BIAS = 50;
   localparam int PD_DIV      = 20;
   localparam int DRIVE_MAX   = 800;
   localparam int DUTY_MID    = 6000;

   // register indexes past the last register, to be ignored
   localparam logic [CSR_INDEX_W-1:0] BAD_INDEX_LOW  = 8'd8;
   localparam logic [CSR_INDEX_W-1:0] BAD_INDEX_HIGH = 8'd255;

   typedef struct packed {
      logic [DUTY_W-1:0]       servo_duty;
      logic signed [ERR_W-1:0] steer_error;
      lost_type                line_lost;
      logic                    clamped;
   } steer_result_type;

   typedef struct {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      logic [SAMPLE_W-1:0]    right_s;
      logic [SAMPLE_W-1:0]    left_s;
      logic [SAMPLE_W-1:0]    center_s;
      logic                   typed;
      steer_result_type       want;
   } step_row_type;

   logic clock;
   logic reset;

   spd_req_if req_ch ();
   spd_rsp_if rsp_ch ();
   spd_csr_if csr_ch ();

   steering_pd_from_three_sensors dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfg_type          shadow_cfg;
   int               last_error;
   steer_result_type expected_q[$];
   step_row_type     step_table[$];
   int               error_count;
   int               idle_cycles;
   logic             sender_burst;
   logic             receiver_burst;

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // shadow copy of the registers, masked to their widths
   function automatic void shadow_write(input logic [CSR_INDEX_W-1:0] index,
                                        input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_SIDE_OFFSET:     shadow_cfg.side_offset = data;
         REG_OFFSET_ON_RIGHT: shadow_cfg.offset_on_right = data[0];
         REG_OUTER_LOW:       shadow_cfg.outer_low = data;
         REG_OUTER_HIGH:      shadow_cfg.outer_high = data;
         REG_CENTER_REF_R:    shadow_cfg.center_ref_right_lost = data;
         REG_CENTER_REF_L:    shadow_cfg.center_ref_left_lost = data;
         REG_GAIN_P:          shadow_cfg.gain_p = data[GAIN_W-1:0];
         REG_GAIN_D:          shadow_cfg.gain_d = data[GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   // next steering response; advances the stored previous error
   function automatic steer_result_type predict_steer(input logic [SAMPLE_W-1:0] right_s,
                                                      input logic [SAMPLE_W-1:0] left_s,
                                                      input logic [SAMPLE_W-1:0] center_s);
      steer_result_type res;
      int               right_v;
      int               left_v;
      int               center_v;
      int               err;
      longint           drive;
      right_v  = int'(right_s);
      left_v   = int'(left_s);
      center_v = int'(center_s);
      res.line_lost = LOST_NONE;
      res.clamped   = 1'b0;
      // offset goes to the side that read weaker at calibration
      if (shadow_cfg.offset_on_right) begin
         right_v += int'(shadow_cfg.side_offset);
      end else begin
         left_v += int'(shadow_cfg.side_offset);
      end
      err = left_v - right_v;
      // lost tests, left checked last so it wins
      if (center_v - int'(shadow_cfg.center_ref_right_lost) < LOST_WINDOW) begin
         err = int'(shadow_cfg.outer_low) - int'(shadow_cfg.outer_high) + FORCED_BIAS;
         res.line_lost = LOST_RIGHT;
      end
      if (center_v - int'(shadow_cfg.center_ref_left_lost) < LOST_WINDOW) begin
         err = int'(shadow_cfg.outer_high) - int'(shadow_cfg.outer_low) - FORCED_BIAS;
         res.line_lost = LOST_LEFT;
      end
      // pd term, truncated toward zero, then clamped
      drive = (longint'(shadow_cfg.gain_p) * longint'(err)
               + longint'(shadow_cfg.gain_d) * (longint'(err) - longint'(last_error)))
              / longint'(PD_DIV);
      last_error = err;
      if (drive < longint'(-DRIVE_MAX)) begin
         drive = longint'(-DRIVE_MAX);
         res.clamped = 1'b1;
      end else if (drive > longint'(DRIVE_MAX)) begin
         drive = longint'(DRIVE_MAX);
         res.clamped = 1'b1;
      end
      res.servo_duty  = DUTY_W'(longint'(DUTY_MID) + drive);
      res.steer_error = ERR_W'(err);
      return res;
   endfunction

   // one sample beat; valid stays high across back-to-back beats
   task automatic send_sample(input logic [SAMPLE_W-1:0] right_s,
                              input logic [SAMPLE_W-1:0] left_s,
                              input logic [SAMPLE_W-1:0] center_s,
                              input logic typed, input steer_result_type want);
      int               gap;
      steer_result_type pred;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.right_sample  <= right_s;
      req_ch.left_sample   <= left_s;
      req_ch.center_sample <= center_s;
      do @(posedge clock); while (!req_ch.ready);
      pred = predict_steer(right_s, left_s, center_s);
      expected_q.push_back(typed ? want : pred);
   endtask

   // drop valid and let every beat in flight come out
   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input int data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_ch.ready);
      shadow_write(index, CSR_DATA_W'(data));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // table builders for the directed part
   task automatic add_csr(input logic [CSR_INDEX_W-1:0] index, input int data);
      step_row_type row;
      row = '{is_csr: 1'b1, index: index, data: CSR_DATA_W'(data), right_s: '0, left_s: '0,
              center_s: '0, typed: 1'b0, want: '0};
      step_table.push_back(row);
   endtask

   task automatic add_sample(input int right_s, input int left_s, input int center_s);
      step_row_type row;
      row = '{is_csr: 1'b0, index: '0, data: '0, right_s: SAMPLE_W'(right_s),
              left_s: SAMPLE_W'(left_s), center_s: SAMPLE_W'(center_s), typed: 1'b0,
              want: '0};
      step_table.push_back(row);
   endtask

   task automatic add_typed(input int right_s, input int left_s, input int center_s,
                            input int duty, input int err, input lost_type lost,
                            input logic clamped);
      step_row_type row;
      row = '{is_csr: 1'b0, index: '0, data: '0, right_s: SAMPLE_W'(right_s),
              left_s: SAMPLE_W'(left_s), center_s: SAMPLE_W'(center_s), typed: 1'b1,
              want: '0};
      row.want.servo_duty  = DUTY_W'(duty);
      row.want.steer_error = ERR_W'(err);
      row.want.line_lost   = lost;
      row.want.clamped     = clamped;
      step_table.push_back(row);
   endtask

   // response ready with random stalls
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // compare each response beat with the oldest expectation
   always @(posedge clock) begin
      steer_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response beat with nothing expected, duty %0d",
                                      rsp_ch.servo_duty));
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.servo_duty !== want.servo_duty)
               report_mismatch($sformatf("servo_duty got %0d want %0d",
                                         rsp_ch.servo_duty, want.servo_duty));
            if (rsp_ch.steer_error !== want.steer_error)
               report_mismatch($sformatf("steer_error got %0d want %0d",
                                         rsp_ch.steer_error, want.steer_error));
            if (rsp_ch.line_lost !== want.line_lost)
               report_mismatch($sformatf("line_lost got %0d want %0d",
                                         rsp_ch.line_lost, want.line_lost));
            if (rsp_ch.clamped !== want.clamped)
               report_mismatch($sformatf("clamped got %0d want %0d",
                                         rsp_ch.clamped, want.clamped));
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("steering_pd_from_three_sensors regression: fail");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      int off_v;
      int on_right_v;
      int base;
      int other;
      int right_i;
      int left_i;
      // known values on every input from time zero
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.right_sample  <= '0;
      req_ch.left_sample   <= '0;
      req_ch.center_sample <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= '0;
      csr_ch.data          <= '0;
      last_error     = 0;
      sender_burst   = 1'b0;
      receiver_burst = 1'b0;
      shadow_cfg     = '0;
      shadow_cfg.gain_p = GAIN_P_RESET;
      shadow_cfg.gain_d = GAIN_D_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset everything reads as left lost with forced error -50
      add_typed(0, 0, 0, 5875, -50, LOST_LEFT, 1'b0);
      add_typed(0, 0, 0, 5925, -50, LOST_LEFT, 1'b0);
      // full-scale sides clamp both ways
      add_typed(0, 8191, 8191, 6800, 8191, LOST_NONE, 1'b1);
      add_typed(8191, 0, 8191, 5200, -8191, LOST_NONE, 1'b1);
      add_sample(100, 100, 8191);
      // edge of the lost window
      add_sample(0, 0, 19);
      add_sample(0, 0, 20);
      // right lost only
      add_csr(REG_CENTER_REF_R, 4000);
      add_csr(REG_OUTER_LOW, 1000);
      add_csr(REG_OUTER_HIGH, 5000);
      add_sample(10, 10, 3000);
      add_sample(10, 10, 4019);
      add_sample(10, 10, 4020);
      // left lost only
      add_csr(REG_CENTER_REF_L, 8191);
      add_sample(1, 2, 8191);
      // widest errors with full offset on either side
      add_csr(REG_CENTER_REF_R, 0);
      add_csr(REG_CENTER_REF_L, 0);
      add_csr(REG_SIDE_OFFSET, 8191);
      add_sample(0, 8191, 8191);
      add_csr(REG_OFFSET_ON_RIGHT, 1);
      add_sample(8191, 0, 8191);
      // zero and full gains
      add_csr(REG_GAIN_P, 0);
      add_csr(REG_GAIN_D, 0);
      add_sample(5, 77, 8191);
      add_csr(REG_GAIN_P, GAIN_MAX);
      add_csr(REG_GAIN_D, GAIN_MAX);
      add_csr(REG_SIDE_OFFSET, 0);
      add_sample(300, 310, 8191);
      add_sample(310, 300, 8191);
      // ignored indexes and data wider than the register
      add_csr(BAD_INDEX_LOW, 'h1FFF);
      add_csr(BAD_INDEX_HIGH, 'h1FFF);
      add_csr(REG_GAIN_P, 'h1F05);
      add_csr(REG_GAIN_D, 'h1F03);
      add_csr(REG_OFFSET_ON_RIGHT, 'h1FFE);
      add_sample(400, 420, 8191);
      add_sample(0, 8191, 100);

      foreach (step_table[i]) begin
         if (step_table[i].is_csr) begin
            settle_pipeline();
            csr_write(step_table[i].index, int'(step_table[i].data));
         end else begin
            send_sample(step_table[i].right_s, step_table[i].left_s,
                        step_table[i].center_s, step_table[i].typed, step_table[i].want);
         end
      end

      // random phases, each with its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         sender_burst   = ($urandom_range(0, 3) == 0);
         receiver_burst = ($urandom_range(0, 3) == 0);
         if (phase == 0) begin
            csr_write(REG_SIDE_OFFSET, SAMPLE_MAX);
            csr_write(REG_OFFSET_ON_RIGHT, 1);
            csr_write(REG_OUTER_LOW, SAMPLE_MAX);
            csr_write(REG_OUTER_HIGH, SAMPLE_MAX);
            csr_write(REG_CENTER_REF_R, SAMPLE_MAX);
            csr_write(REG_CENTER_REF_L, SAMPLE_MAX);
            csr_write(REG_GAIN_P, GAIN_MAX);
            csr_write(REG_GAIN_D, GAIN_MAX);
         end else if (phase == 1) begin
            csr_write(REG_SIDE_OFFSET, 0);
            csr_write(REG_OFFSET_ON_RIGHT, 0);
            csr_write(REG_OUTER_LOW, 0);
            csr_write(REG_OUTER_HIGH, 0);
            csr_write(REG_CENTER_REF_R, 0);
            csr_write(REG_CENTER_REF_L, 0);
            csr_write(REG_GAIN_P, 0);
            csr_write(REG_GAIN_D, 0);
         end else begin
            csr_write(REG_SIDE_OFFSET, $urandom_range(0, 1) ? $urandom_range(0, 400)
                                                            : $urandom_range(0, SAMPLE_MAX));
            csr_write(REG_OFFSET_ON_RIGHT, $urandom_range(0, 1));
            csr_write(REG_OUTER_LOW, $urandom_range(0, SAMPLE_MAX));
            csr_write(REG_OUTER_HIGH, $urandom_range(0, SAMPLE_MAX));
            csr_write(REG_CENTER_REF_R, ($urandom_range(0, 3) == 0)
                      ? $urandom_range(0, SAMPLE_MAX) : $urandom_range(0, 1500));
            csr_write(REG_CENTER_REF_L, ($urandom_range(0, 3) == 0)
                      ? $urandom_range(0, SAMPLE_MAX) : $urandom_range(0, 1500));
            csr_write(REG_GAIN_P, $urandom_range(0, GAIN_MAX));
            csr_write(REG_GAIN_D, $urandom_range(0, GAIN_MAX));
         end
         off_v      = int'(shadow_cfg.side_offset);
         on_right_v = int'(shadow_cfg.offset_on_right);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 9) < 6) begin
               // nearly balanced sides once the offset is counted, so the tracking
               // error stays small
               base  = $urandom_range(0, SAMPLE_MAX);
               other = base + $urandom_range(0, 400) - 200 + (on_right_v ? off_v : -off_v);
               if (other < 0) other = 0;
               if (other > SAMPLE_MAX) other = SAMPLE_MAX;
               right_i = base;
               left_i  = other;
            end else begin
               right_i = $urandom_range(0, SAMPLE_MAX);
               left_i  = $urandom_range(0, SAMPLE_MAX);
            end
            send_sample(SAMPLE_W'(right_i), SAMPLE_W'(left_i),
                        SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);
         end
      end

      settle_pipeline();
      if (error_count == 0) begin
         $display("steering_pd_from_three_sensors regression: pass");
      end else begin
         $display("steering_pd_from_three_sensors regression: fail");
      end
      $finish;
   end

endmodule

### steering_pd_from_three_sensors.f
+incdir+design
design/spd_pkg.sv
design/spd_if.sv
design/spd_front.sv
design/spd_queue.sv
design/spd_back.sv
design/steering_pd_from_three_sensors.sv
tb/steering_pd_from_three_sensors_tb.sv
